### hw/rtl/irrf_pkg.sv
// ----------------------------------------------------------------------------
// irrf_pkg
// Shared types, sizes and tables of the infrared rank filter block.
// ----------------------------------------------------------------------------
package irrf_pkg;

  localparam int RING_DEPTH   = 8;
  localparam int SENSOR_COUNT = 5;

  localparam int CH_W      = 3;
  localparam int SMP_W     = 8;
  localparam int LIN_W     = 7;
  localparam int POS_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SENSOR_W  = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int MEM_DEPTH = RING_DEPTH * SENSOR_COUNT;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CH_W-1:0]  FRONT_A   = CH_W'(2);
  localparam logic [CH_W-1:0]  FRONT_B   = CH_W'(3);
  localparam logic [SMP_W-1:0] TABLE_TOP = SMP_W'(117);
  localparam logic [SMP_W-1:0] CENTER    = SMP_W'(127);
  localparam logic [SMP_W-1:0] SMP_MAX   = SMP_W'(255);

  localparam logic [SMP_W-1:0] NEAR_THR_RST = SMP_W'(30);
  localparam logic [LIN_W-1:0] MID_SUB_RST  = LIN_W'(48);

  // Register indexes on the configuration port
  localparam logic REG_NEAR_THR = 1'b0;
  localparam logic REG_MID_SUB  = 1'b1;

  // Distance linearization, indexed by the plausible front reading
  localparam logic [LIN_W-1:0] LIN_TABLE [118] = '{
    7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127,
    7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127,
    7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127,
    7'd119, 7'd112, 7'd108, 7'd104, 7'd100, 7'd96,  7'd93,  7'd90,  7'd86,  7'd83,
    7'd80,  7'd77,  7'd74,  7'd71,  7'd69,  7'd66,  7'd64,  7'd62,  7'd61,  7'd59,
    7'd57,  7'd55,  7'd53,  7'd51,  7'd49,  7'd48,  7'd47,  7'd45,  7'd44,  7'd42,
    7'd41,  7'd40,  7'd38,  7'd36,  7'd34,  7'd33,  7'd32,  7'd31,  7'd30,  7'd29,
    7'd28,  7'd27,  7'd26,  7'd25,  7'd24,  7'd23,  7'd22,  7'd21,  7'd20,  7'd19,
    7'd18,  7'd17,  7'd16,  7'd16,  7'd15,  7'd15,  7'd14,  7'd14,  7'd13,  7'd13,
    7'd12,  7'd12,  7'd11,  7'd11,  7'd10,  7'd10,  7'd9,   7'd9,   7'd8,   7'd8,
    7'd7,   7'd7,   7'd6,   7'd6,   7'd5,   7'd5,   7'd4,   7'd4,   7'd3,   7'd3,
    7'd3,   7'd2,   7'd2,   7'd2,   7'd1,   7'd1,   7'd1,   7'd0
  };

  // Clamp a filtered front reading into the table and look it up
  function automatic logic [LIN_W-1:0] lin_front(input logic [SMP_W-1:0] filt,
                                                 input logic [SMP_W-1:0] thr,
                                                 input logic [LIN_W-1:0] mid);
    logic [SMP_W-1:0] idx;
    begin
      if (filt > TABLE_TOP) begin
        idx = TABLE_TOP;
      end else if (filt < thr) begin
        idx = ({1'b0, mid} > TABLE_TOP) ? TABLE_TOP : {1'b0, mid};
      end else begin
        idx = filt;
      end
      lin_front = LIN_TABLE[idx[LIN_W-1:0]];
    end
  endfunction

  // One classified request on its way from front to back
  typedef struct packed {
    logic [SENSOR_W-1:0] ch_idx;
    logic [SMP_W-1:0]    sample;
    logic                has_ring;
    logic                is_fa;
    logic                is_fb;
  } irrf_item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_WRITE,
    B_READ,
    B_DRAIN,
    B_CACHE,
    B_EMIT
  } irrf_bstate_e;

endpackage

### hw/rtl/irrf_front.sv
// ----------------------------------------------------------------------------
// irrf_front
// Accepts sample requests, classifies the channel and queues them.
// ----------------------------------------------------------------------------
module irrf_front import irrf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CH_W-1:0]  in_channel_i,
  input  logic [SMP_W-1:0] in_sample_i,
  output logic             q_valid_o,
  output irrf_item_t       q_head_o,
  input  logic             q_pop_i
);

  irrf_item_t  entry_q [QUEUE_DEPTH];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push;
  irrf_item_t  item;

  always_comb begin
    item.ch_idx   = in_channel_i[SENSOR_W-1:0];
    item.sample   = in_sample_i;
    item.has_ring = ({1'b0, in_channel_i} < (CH_W+1)'(SENSOR_COUNT));
    item.is_fa    = (in_channel_i == FRONT_A);
    item.is_fb    = (in_channel_i == FRONT_B);
  end

  assign in_ready_o = (count_q != 2'(QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_head_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item;
    end
  end

endmodule

### hw/rtl/irrf_back.sv
// ----------------------------------------------------------------------------
// irrf_back
// Writes the ring, walks it for the third smallest entry and forms results.
// ----------------------------------------------------------------------------
module irrf_back import irrf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  irrf_item_t       q_head_i,
  output logic             q_pop_o,
  input  logic [SMP_W-1:0] near_thr_i,
  input  logic [LIN_W-1:0] mid_sub_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [SMP_W-1:0] out_filtered_o,
  output logic [SMP_W-1:0] out_offset_o,
  output logic             out_crossing_o
);

  irrf_bstate_e state_q, state_d;

  // Ring storage with per-entry valid bits standing in for the reset clear
  logic [SMP_W-1:0]  ring_mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] ring_vld_q;
  logic [POS_W-1:0]  wr_pos_q [SENSOR_COUNT];

  irrf_item_t        item_q;
  logic [ADDR_W-1:0] base_q;
  logic [POS_W-1:0]  rd_cnt_q;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [POS_W-1:0]  cur_pos;
  logic [SMP_W-1:0]  rd_data_q;
  logic              rd_ok_q;
  logic              rd_live_q;
  logic [SMP_W-1:0]  a_q, b_q, c_q, a_d, b_d, c_d, v;
  logic [SMP_W-1:0]  fa_q, fb_q, filt_q;
  logic [LIN_W-1:0]  lin_a, lin_b;

  logic              mem_we, rd_en, load_out, last_rd;

  logic              out_valid_q;
  logic [SMP_W-1:0]  out_filt_q, out_offs_q;
  logic              out_cross_q;

  assign cur_pos = wr_pos_q[item_q.ch_idx];
  assign wr_addr = base_q + ADDR_W'(cur_pos);
  assign rd_addr = base_q + ADDR_W'(rd_cnt_q);
  assign last_rd = (rd_cnt_q == POS_W'(RING_DEPTH - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          state_d = q_head_i.has_ring ? B_WRITE : B_EMIT;
        end
      end
      B_WRITE: state_d = B_READ;
      B_READ: begin
        if (last_rd) begin
          state_d = B_DRAIN;
        end
      end
      B_DRAIN: state_d = B_CACHE;
      B_CACHE: state_d = B_EMIT;
      B_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop_o  = 1'b0;
    mem_we   = 1'b0;
    rd_en    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      B_IDLE:  q_pop_o  = q_valid_i;
      B_WRITE: mem_we   = 1'b1;
      B_READ:  rd_en    = 1'b1;
      B_EMIT:  load_out = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // Insert the entry just read into the three smallest so far
  always_comb begin
    v   = rd_ok_q ? rd_data_q : '0;
    a_d = a_q;
    b_d = b_q;
    c_d = c_q;
    if (v < a_q) begin
      c_d = b_q;
      b_d = a_q;
      a_d = v;
    end else if (v < b_q) begin
      c_d = b_q;
      b_d = v;
    end else if (v < c_q) begin
      c_d = v;
    end
  end

  assign lin_a = lin_front(fa_q, near_thr_i, mid_sub_i);
  assign lin_b = lin_front(fb_q, near_thr_i, mid_sub_i);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[wr_addr] <= item_q.sample;
    end
    if (rd_en) begin
      rd_data_q <= ring_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      ring_vld_q  <= '0;
      rd_ok_q     <= 1'b0;
      rd_live_q   <= 1'b0;
      out_valid_q <= 1'b0;
      fa_q        <= '0;
      fb_q        <= '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        wr_pos_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      rd_live_q <= rd_en;
      if (rd_en) begin
        rd_ok_q <= ring_vld_q[rd_addr];
      end
      if (mem_we) begin
        ring_vld_q[wr_addr]     <= 1'b1;
        wr_pos_q[item_q.ch_idx] <= (cur_pos == POS_W'(RING_DEPTH - 1)) ?
                                   '0 : cur_pos + POS_W'(1);
      end
      if (state_q == B_CACHE) begin
        if (item_q.is_fa) begin
          fa_q <= c_q;
        end
        if (item_q.is_fb) begin
          fb_q <= c_q;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_head_i;
      base_q <= ADDR_W'(ADDR_W'(q_head_i.ch_idx) * ADDR_W'(RING_DEPTH));
      filt_q <= '0;
    end
    if (mem_we) begin
      a_q      <= SMP_MAX;
      b_q      <= SMP_MAX;
      c_q      <= SMP_MAX;
      rd_cnt_q <= '0;
    end else begin
      if (rd_en) begin
        rd_cnt_q <= rd_cnt_q + POS_W'(1);
      end
      if (rd_live_q) begin
        a_q <= a_d;
        b_q <= b_d;
        c_q <= c_d;
      end
    end
    if (state_q == B_CACHE) begin
      filt_q <= c_q;
    end
    if (load_out) begin
      out_filt_q  <= filt_q;
      out_offs_q  <= CENTER + {1'b0, lin_a} - {1'b0, lin_b};
      out_cross_q <= (fa_q < near_thr_i) || (fb_q < near_thr_i);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_filtered_o = out_filt_q;
  assign out_offset_o   = out_offs_q;
  assign out_crossing_o = out_cross_q;

  a_pop_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("pop from empty queue");

  a_write_then_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_WRITE |=> state_q == B_READ && rd_cnt_q == '0)
    else $error("ring walk did not start after write");

  a_live_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_live_q |-> $past(state_q) == B_READ)
    else $error("accumulate without a read");

  a_emit_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_EMIT && out_valid_q && !out_ready_i) |=> state_q == B_EMIT)
    else $error("result dropped while output stalled");

endmodule

### hw/rtl/ir_rank_filter_center_offset.sv
// ----------------------------------------------------------------------------
// ir_rank_filter_center_offset
// Five-channel IR rank filter with front centering offset and crossing flag.
// ----------------------------------------------------------------------------
//  Channel   Direction  Ports            Payload (low bit up)
//  s_axis    in         tvalid/tready    tdata: channel[2:0], sample[10:3]
//  m_axis    out        tvalid/tready    tdata: channel_filtered[7:0],
//                                               center_offset[15:8],
//                                               crossing[16]
//  apb       in         psel/penable     0x0 near_threshold, 0x4 middle_substitute
//
//  Sequence: a request passes the back end as pop, ring write, eight ring
//  reads, drain, cache, emit; the eight reads go through the single read
//  port of the ring memory. A channel without a sensor skips the ring and
//  goes from pop straight to emit.
//  Reset: rings read as zero through per-entry valid bits, so no clearing pass.
//  Stalls: a two-entry queue parts intake from the back end, and an output
//  register holds a finished result while the next request is accepted.
// ----------------------------------------------------------------------------
module ir_rank_filter_center_offset import irrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Sample requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // channel[2:0], sample[10:3], zero fill
  // Results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // channel_filtered[7:0], center_offset[15:8],
                                      // crossing[16], zero fill
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [SMP_W-1:0] near_thr_q;
  logic [LIN_W-1:0] mid_sub_q;
  logic             cfg_wr;

  logic             q_valid, q_pop;
  irrf_item_t       q_head;

  logic [SMP_W-1:0] out_filt, out_offs;
  logic             out_cross;

  // Configuration registers: one write per access phase, reads always ready
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_thr_q <= NEAR_THR_RST;
      mid_sub_q  <= MID_SUB_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_NEAR_THR) begin
        near_thr_q <= pwdata[SMP_W-1:0];
      end else begin
        mid_sub_q <= pwdata[LIN_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_MID_SUB) ? {25'b0, mid_sub_q} : {24'b0, near_thr_q};

  // Intake: classify and queue
  irrf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_channel_i (s_axis_tdata[2:0]),
    .in_sample_i  (s_axis_tdata[10:3]),
    .q_valid_o    (q_valid),
    .q_head_o     (q_head),
    .q_pop_i      (q_pop)
  );

  // Ring update, rank walk and result forming
  irrf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_head_i       (q_head),
    .q_pop_o        (q_pop),
    .near_thr_i     (near_thr_q),
    .mid_sub_i      (mid_sub_q),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_filtered_o (out_filt),
    .out_offset_o   (out_offs),
    .out_crossing_o (out_cross)
  );

  assign m_axis_tdata = {7'b0, out_cross, out_offs, out_filt};

endmodule
